// ===== src/mcsd_pkg.sv =====
package mcsd_pkg;

   typedef enum logic [3:0] {
      PH_TYPE,
      PH_SIZE,
      PH_PAL,
      PH_PALPAD,
      PH_SND,
      PH_IMG_Y0,
      PH_IMG_Y1,
      PH_IMG_X,
      PH_IMG_N,
      PH_IMG_COPY
   } phase_type;

   typedef enum logic [2:0] {
      KIND_PALETTE = 3'd0,
      KIND_PIXEL   = 3'd1,
      KIND_SOUND   = 3'd2,
      KIND_FRAME   = 3'd3,
      KIND_SERVE   = 3'd4
   } kind_type;

   localparam int unsigned CHUNK_PALETTE = 0;
   localparam int unsigned CHUNK_SOUND   = 1;
   localparam int unsigned CHUNK_IMAGE   = 2;
   localparam int unsigned CHUNK_DONE    = 3;
   localparam int unsigned CHUNK_OTHER   = 4;

   localparam logic [9:0] PAL_LAST     = 10'd767;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic CSR_OVERSCAN = 1'b0;
   localparam logic CSR_STRIDE   = 1'b1;

   // one queued command: a single result, or the four overscan pixel writes
   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [7:0]  value;
      logic        pad;
   } cmd_type;

endpackage

// ===== src/mcsd_front.sv =====
module mcsd_front
   import mcsd_pkg::*;
#(
   parameter int unsigned RING_BYTES  = 22050,
   parameter int unsigned SERVE_BYTES = 2205,
   parameter int unsigned FRAME_BYTES = 64000
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic       action,
   input  logic [7:0] data_byte,
   input  logic [7:0] overscan_index,
   input  logic [9:0] row_stride,
   output logic       cmd_valid,
   output cmd_type    cmd
);

   localparam logic [14:0] RING_LAST  = 15'(RING_BYTES - 1);
   localparam logic [15:0] RING_W     = 16'(RING_BYTES);
   localparam logic [15:0] SERVE_STEP = 16'(SERVE_BYTES % RING_BYTES);
   localparam logic [31:0] RING_32    = 32'(RING_BYTES);
   localparam logic [31:0] SERVE_32   = 32'(SERVE_BYTES);
   localparam logic [26:0] FRAME_27   = 27'(FRAME_BYTES);

   phase_type          phase_ff, phase_in;
   logic [2:0]         type_ff, type_in;
   logic signed [32:0] size_ff, size_in;
   logic [9:0]         idx_ff, idx_in;
   logic [26:0]        pp_ff, pp_in;
   logic [7:0]         run_ff, run_in;
   logic [14:0]        wptr_ff, wptr_in;
   logic [14:0]        rptr_ff, rptr_in;
   logic [31:0]        stored_ff, stored_in;
   logic [31:0]        served_ff, served_in;
   logic               accept_ff, accept_in;

   logic [32:0]        size_full;
   logic signed [32:0] size_m1, size_m2;
   logic [15:0]        rsum;
   logic [7:0]         tnorm;

   always_comb begin
      size_full = size_ff;
      case (idx_ff[1:0])
         2'd0: size_full[7:0]   = data_byte;
         2'd1: size_full[15:8]  = data_byte;
         2'd2: size_full[23:16] = data_byte;
         default: size_full[31:24] = data_byte;
      endcase
      size_m1 = size_ff - 33'sd1;
      size_m2 = size_ff - 33'sd2;
      rsum    = {1'b0, rptr_ff} + SERVE_STEP;
      tnorm   = data_byte - 8'd1;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (!action) begin
         case (phase_ff)
            PH_TYPE: phase_in = PH_SIZE;
            PH_SIZE: begin
               if (idx_ff[1:0] == 2'd3) begin
                  phase_in = PH_TYPE;
                  case (type_ff)
                     3'(CHUNK_PALETTE): phase_in = PH_PAL;
                     3'(CHUNK_SOUND):
                        if (size_full[31:0] != 32'd0) phase_in = PH_SND;
                     3'(CHUNK_IMAGE):
                        if (size_full[31:0] != 32'd0) phase_in = PH_IMG_Y0;
                     default: phase_in = PH_TYPE;
                  endcase
               end
            end
            PH_PAL:    if (idx_ff == PAL_LAST) phase_in = PH_PALPAD;
            PH_PALPAD: phase_in = PH_TYPE;
            PH_SND:    if (size_m1 <= 33'sd0) phase_in = PH_TYPE;
            PH_IMG_Y0: phase_in = PH_IMG_Y1;
            PH_IMG_Y1: phase_in = (size_m2 > 33'sd0) ? PH_IMG_X : PH_TYPE;
            PH_IMG_X:  phase_in = PH_IMG_N;
            PH_IMG_N: begin
               if (data_byte != 8'd0) phase_in = PH_IMG_COPY;
               else phase_in = (size_m2 > 33'sd0) ? PH_IMG_X : PH_TYPE;
            end
            PH_IMG_COPY:
               if (run_ff == 8'd1) phase_in = (size_m1 > 33'sd0) ? PH_IMG_X : PH_TYPE;
            default: phase_in = PH_TYPE;
         endcase
      end
   end

   // datapath and commands
   always_comb begin
      type_in   = type_ff;
      size_in   = size_ff;
      idx_in    = idx_ff;
      pp_in     = pp_ff;
      run_in    = run_ff;
      wptr_in   = wptr_ff;
      rptr_in   = rptr_ff;
      stored_in = stored_ff;
      served_in = served_ff;
      accept_in = accept_ff;
      cmd_valid = 1'b0;
      cmd       = '{kind: KIND_PALETTE, address: 16'd0, value: 8'd0, pad: 1'b0};
      if (action) begin
         cmd_valid   = 1'b1;
         cmd.kind    = KIND_SERVE;
         cmd.address = {1'b0, rptr_ff};
         rptr_in     = (rsum >= RING_W) ? 15'(rsum - RING_W) : rsum[14:0];
         served_in   = served_ff + SERVE_32;
      end else begin
         case (phase_ff)
            PH_TYPE: begin
               type_in = (tnorm > 8'd3) ? 3'(CHUNK_OTHER) : tnorm[2:0];
               idx_in  = 10'd0;
               size_in = 33'sd0;
            end
            PH_SIZE: begin
               size_in = size_full;
               idx_in  = idx_ff + 10'd1;
               if (idx_ff[1:0] == 2'd3) begin
                  idx_in = 10'd0;
                  case (type_ff)
                     3'(CHUNK_SOUND): accept_in = (stored_ff - served_ff) < RING_32;
                     3'(CHUNK_IMAGE): size_in = {size_full[31], size_full[31:0]};
                     3'(CHUNK_DONE): begin
                        cmd_valid = 1'b1;
                        cmd.kind  = KIND_FRAME;
                     end
                     default: ;
                  endcase
               end
            end
            PH_PAL: begin
               cmd_valid   = 1'b1;
               cmd.kind    = KIND_PALETTE;
               cmd.address = {6'd0, idx_ff};
               cmd.value   = {data_byte[5:0], 2'b00};
               idx_in      = idx_ff + 10'd1;
            end
            PH_PALPAD: begin
               cmd_valid = 1'b1;
               cmd.kind  = KIND_PIXEL;
               cmd.value = overscan_index;
               cmd.pad   = 1'b1;
            end
            PH_SND: begin
               if (accept_ff) begin
                  cmd_valid   = 1'b1;
                  cmd.kind    = KIND_SOUND;
                  cmd.address = {1'b0, wptr_ff};
                  cmd.value   = data_byte;
                  stored_in   = stored_ff + 32'd1;
                  wptr_in     = (wptr_ff == RING_LAST) ? 15'd0 : wptr_ff + 15'd1;
               end
               size_in = size_m1;
            end
            PH_IMG_Y0: pp_in = {19'd0, data_byte};
            PH_IMG_Y1: begin
               pp_in   = {11'd0, data_byte, pp_ff[7:0]} * {17'd0, row_stride};
               size_in = size_m2;
            end
            PH_IMG_X: pp_in = pp_ff + {19'd0, data_byte};
            PH_IMG_N: begin
               run_in  = data_byte;
               size_in = size_m2;
            end
            PH_IMG_COPY: begin
               if (pp_ff < FRAME_27) begin
                  cmd_valid   = 1'b1;
                  cmd.kind    = KIND_PIXEL;
                  cmd.address = pp_ff[15:0];
                  cmd.value   = data_byte;
               end
               pp_in   = pp_ff + 27'd1;
               size_in = size_m1;
               run_in  = run_ff - 8'd1;
            end
            default: ;
         endcase
      end
      cmd_valid = cmd_valid & take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         type_ff   <= 3'd0;
         size_ff   <= 33'sd0;
         idx_ff    <= 10'd0;
         pp_ff     <= 27'd0;
         run_ff    <= 8'd0;
         wptr_ff   <= 15'd0;
         rptr_ff   <= 15'd0;
         stored_ff <= 32'd0;
         served_ff <= 32'd0;
         accept_ff <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         size_ff   <= size_in;
         idx_ff    <= idx_in;
         pp_ff     <= pp_in;
         run_ff    <= run_in;
         wptr_ff   <= wptr_in;
         rptr_ff   <= rptr_in;
         stored_ff <= stored_in;
         served_ff <= served_in;
         accept_ff <= accept_in;
      end
   end

endmodule

// ===== src/mcsd_queue.sv =====
module mcsd_queue
   import mcsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type             mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, rd_ff;
   logic [QPTR_W:0]     count_ff;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
      end
   end

endmodule

// ===== src/mcsd_back.sv =====
module mcsd_back
   import mcsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  cmd_type     head,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic [1:0]  pad_ff;
   logic        valid_ff;
   kind_type    kind_ff;
   logic [15:0] addr_ff;
   logic [7:0]  value_ff;
   logic        last_ff;
   logic        load;
   logic        pad_end;

   assign load    = head_valid && (!valid_ff || rsp_tready);
   assign pad_end = (pad_ff == 2'd3);
   assign pop     = load && (!head.pad || pad_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pad_ff   <= 2'd0;
      end else begin
         if (load) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
         if (load && head.pad) pad_ff <= pad_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= head.kind;
         addr_ff  <= head.pad ? {14'd0, pad_ff} : head.address;
         value_ff <= head.value;
         last_ff  <= !head.pad || pad_end;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {value_ff, addr_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== src/movie_chunk_stream_decoder_core.sv =====
// path: a result goes through the result queue and output register to rsp
// throughput: one byte or serve request per cycle while the queue is not
// full; the byte that ends a palette gives four pixel writes, sent one
// per cycle from the result queue while rsp is ready
// reset: synchronous, active high; parser, ring pointers, counters and
// queue clear, registers return to overscan 0 and stride 200
module movie_chunk_stream_decoder_core
   import mcsd_pkg::*;
#(
   parameter int unsigned RING_BYTES  = 22050,
   parameter int unsigned SERVE_BYTES = 2205,
   parameter int unsigned FRAME_BYTES = 64000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // address[15:0], value[23:16]
   output logic [2:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [9:0]  csr_wdata
);

   logic [7:0] overscan_ff;
   logic [9:0] stride_ff;
   logic       take, cmd_valid, full, not_empty, pop;
   cmd_type    cmd, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         overscan_ff <= 8'd0;
         stride_ff   <= 10'd200;
      end else if (csr_we) begin
         if (csr_addr == CSR_OVERSCAN) overscan_ff <= csr_wdata[7:0];
         if (csr_addr == CSR_STRIDE) stride_ff <= csr_wdata;
      end
   end

   assign req_tready = !full;
   assign take       = req_tvalid && req_tready;

   mcsd_front #(
      .RING_BYTES (RING_BYTES),
      .SERVE_BYTES(SERVE_BYTES),
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .action        (req_tuser),
      .data_byte     (req_tdata),
      .overscan_index(overscan_ff),
      .row_stride    (stride_ff),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd)
   );

   mcsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_valid),
      .push_cmd (cmd),
      .pop      (pop),
      .full     (full),
      .not_empty(not_empty),
      .head     (head)
   );

   mcsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // only the overscan writes can be a non-last result
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == KIND_PIXEL && rsp_tdata[15:2] == 14'd0)
      else $error("non-last result outside overscan writes");

   a_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_FRAME |-> rsp_tdata == 24'd0)
      else $error("frame done with nonzero payload");

   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");

endmodule
